>>> sv/fcsb_pkg.sv
package fcsb_pkg;

    // plane count and register port geometry
    localparam int NUM_PLANES = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int PLANE_W    = 64;

    // field widths
    localparam int COORD_W    = 16;
    localparam int RAD_W      = 15;
    localparam int FRAC_BITS  = 14;
    localparam int PROD_W     = 2 * COORD_W;
    // three products plus distance and radius terms, signed
    localparam int DIST_W     = PROD_W + 2;

    // item kind codes
    localparam logic KIND_SPHERE = 1'b0;
    localparam logic KIND_BOX    = 1'b1;

    // one item as it travels down the chain
    typedef struct packed {
        logic                       kind;
        logic signed [COORD_W-1:0]  lo_x;
        logic signed [COORD_W-1:0]  lo_y;
        logic signed [COORD_W-1:0]  lo_z;
        logic signed [COORD_W-1:0]  hi_x;
        logic signed [COORD_W-1:0]  hi_y;
        logic signed [COORD_W-1:0]  hi_z;
        logic        [RAD_W-1:0]    radius;
    } item_t;

    // running verdict handed from cell to cell
    typedef struct packed {
        logic touches;
        logic all_in;
    } flags_t;

endpackage

>>> sv/fcsb_cell.sv
// One plane test cell: products in the first stage, sums and compares in the second.
module fcsb_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [fcsb_pkg::PLANE_W-1:0]    plane,
    input  logic                            in_valid,
    input  fcsb_pkg::item_t                 in_item,
    input  fcsb_pkg::flags_t                in_flags,
    output logic                            out_valid,
    output fcsb_pkg::item_t                 out_item,
    output fcsb_pkg::flags_t                out_flags
);

    localparam int CW = fcsb_pkg::COORD_W;
    localparam int PW = fcsb_pkg::PROD_W;
    localparam int DW = fcsb_pkg::DIST_W;
    localparam int FB = fcsb_pkg::FRAC_BITS;

    // plane fields
    logic signed [CW-1:0] nx, ny, nz, dd;
    assign nx = plane[CW-1:0];
    assign ny = plane[2*CW-1:CW];
    assign nz = plane[3*CW-1:2*CW];
    assign dd = plane[4*CW-1:3*CW];

    // stage A: products
    logic signed [PW-1:0] plo_next [3];
    logic signed [PW-1:0] phi_next [3];
    logic signed [PW-1:0] plo_reg  [3];
    logic signed [PW-1:0] phi_reg  [3];
    logic                 a_valid_reg;
    fcsb_pkg::item_t      a_item_reg;
    fcsb_pkg::flags_t     a_flags_reg;

    always_comb
    begin
        plo_next[0] = nx * in_item.lo_x;
        plo_next[1] = ny * in_item.lo_y;
        plo_next[2] = nz * in_item.lo_z;
        phi_next[0] = nx * in_item.hi_x;
        phi_next[1] = ny * in_item.hi_y;
        phi_next[2] = nz * in_item.hi_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            plo_reg     <= plo_next;
            phi_reg     <= phi_next;
            a_item_reg  <= in_item;
            a_flags_reg <= in_flags;
        end
    end

    // stage B: best and worst corner, sphere centre, verdict update
    logic signed [DW-1:0] d_term;
    logic signed [DW-1:0] r_term;
    logic signed [DW-1:0] dist_max, dist_min, dist_ctr, sphere_margin;
    logic signed [PW-1:0] big [3];
    logic signed [PW-1:0] sml [3];
    fcsb_pkg::flags_t     flags_next;

    assign d_term = {{(DW-CW-FB){dd[CW-1]}}, dd, {FB{1'b0}}};
    assign r_term = {{(DW-fcsb_pkg::RAD_W-FB){1'b0}}, a_item_reg.radius, {FB{1'b0}}};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            big[k] = (plo_reg[k] > phi_reg[k]) ? plo_reg[k] : phi_reg[k];
            sml[k] = (plo_reg[k] > phi_reg[k]) ? phi_reg[k] : plo_reg[k];
        end
        dist_max = DW'(big[0]) + DW'(big[1]) + DW'(big[2]) + d_term;
        dist_min = DW'(sml[0]) + DW'(sml[1]) + DW'(sml[2]) + d_term;
        dist_ctr = DW'(plo_reg[0]) + DW'(plo_reg[1]) + DW'(plo_reg[2]) + d_term;
        sphere_margin = dist_ctr + r_term;

        flags_next = a_flags_reg;
        unique case (a_item_reg.kind)
            fcsb_pkg::KIND_SPHERE:
            begin
                if (sphere_margin < 0)
                    flags_next.touches = 1'b0;
            end
            fcsb_pkg::KIND_BOX:
            begin
                if (!(dist_max > 0))
                    flags_next.touches = 1'b0;
                if (!(dist_min > 0))
                    flags_next.all_in = 1'b0;
            end
            default:
            begin
                flags_next = a_flags_reg;
            end
        endcase
    end

    logic             b_valid_reg;
    fcsb_pkg::item_t  b_item_reg;
    fcsb_pkg::flags_t b_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_item_reg  <= a_item_reg;
            b_flags_reg <= flags_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;
    assign out_flags = b_flags_reg;

endmodule

>>> sv/frustum_cull_sphere_box_core.sv
// Pipeline: two stages (A and B) in each of six plane cells between input accept and out_valid.
// Throughput: one word per cycle; the cell chain stalls as a whole only when the
// last cell holds a result that out_ready does not take.
// Config port is always ready; writes to indexes above five are dropped.
// Reset (rst_n, async, active low) empties the chain and clears all six planes to zero.
module frustum_cull_sphere_box_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic signed [fcsb_pkg::COORD_W-1:0] first_x,
    input  logic signed [fcsb_pkg::COORD_W-1:0] first_y,
    input  logic signed [fcsb_pkg::COORD_W-1:0] first_z,
    input  logic signed [fcsb_pkg::COORD_W-1:0] second_x,
    input  logic signed [fcsb_pkg::COORD_W-1:0] second_y,
    input  logic signed [fcsb_pkg::COORD_W-1:0] second_z,
    input  logic        [fcsb_pkg::RAD_W-1:0]   radius,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fcsb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fcsb_pkg::PLANE_W-1:0]        cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                touches,
    output logic                                fully_inside
);

    localparam int NP = fcsb_pkg::NUM_PLANES;

    // plane registers
    logic [fcsb_pkg::PLANE_W-1:0] plane_reg  [NP];
    logic [fcsb_pkg::PLANE_W-1:0] plane_next [NP];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            plane_next[i] = plane_reg[i];
            if (cfg_valid && (cfg_index == fcsb_pkg::CFG_IDX_W'(i)))
                plane_next[i] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++)
                plane_reg[i] <= '0;
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

    // chain links
    logic             link_valid [NP+1];
    fcsb_pkg::item_t  link_item  [NP+1];
    fcsb_pkg::flags_t link_flags [NP+1];
    logic             advance;

    // whole chain moves unless the last result is stuck
    assign advance  = !link_valid[NP] || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        link_valid[0]         = in_valid;
        link_item[0].kind     = kind;
        link_item[0].lo_x     = first_x;
        link_item[0].lo_y     = first_y;
        link_item[0].lo_z     = first_z;
        link_item[0].hi_x     = second_x;
        link_item[0].hi_y     = second_y;
        link_item[0].hi_z     = second_z;
        link_item[0].radius   = radius;
        link_flags[0].touches = 1'b1;
        link_flags[0].all_in  = (kind == fcsb_pkg::KIND_BOX);
    end

    for (genvar g = 0; g < NP; g++)
    begin : g_cell
        fcsb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .plane     (plane_reg[g]),
            .in_valid  (link_valid[g]),
            .in_item   (link_item[g]),
            .in_flags  (link_flags[g]),
            .out_valid (link_valid[g+1]),
            .out_item  (link_item[g+1]),
            .out_flags (link_flags[g+1])
        );
    end

    // last cell register is the output word
    assign out_valid    = link_valid[NP];
    assign touches      = link_flags[NP].touches;
    assign fully_inside = link_flags[NP].all_in;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import fcsb_pkg::*;

    localparam int     CLK_PERIOD  = 10;
    localparam int     LATENCY     = 12;
    localparam int     CYCLE_LIMIT = 200_000;
    localparam longint Q_ONE       = longint'(1) << FRAC_BITS;

    // plane register indexes; six and seven are unused slots
    localparam int REG_LEFT     = 0;
    localparam int REG_RIGHT    = 1;
    localparam int REG_TOP      = 2;
    localparam int REG_BOTTOM   = 3;
    localparam int REG_NEAR     = 4;
    localparam int REG_FAR      = 5;
    localparam int REG_SPARE_LO = 6;
    localparam int REG_SPARE_HI = 7;

    // Q2.14 unit normals and the view-box extents
    localparam logic [15:0] Q_POS    = 16'h4000;
    localparam logic [15:0] Q_NEG    = 16'hC000;
    localparam logic [15:0] Q_ZERO   = 16'h0000;
    localparam logic [15:0] VIEW_W   = 16'd8000;
    localparam logic [15:0] VIEW_FAR = 16'd20000;

    typedef struct {
        logic hit;
        logic all_in;
    } verdict_t;

    // Tracks the plane set, predicts the cull verdict per word, checks results
    class cull_scoreboard;
        logic [63:0] plane_reg [NUM_PLANES];
        verdict_t    verdict_q [$];
        int          mismatches;
        int          orphans;
        int          checked;
        int          n_spheres;
        int          n_boxes;
        int          n_culled;
        int          n_inside;

        function new();
            for (int i = 0; i < NUM_PLANES; i++)
                plane_reg[i] = '0;
        endfunction

        function void write_plane(int idx, logic [63:0] data);
            if (idx < NUM_PLANES)
                plane_reg[idx] = data;
        endfunction

        // exact signed distance in units of 2^-14
        function longint plane_dist(logic [63:0] p, longint x, longint y, longint z);
            longint nx, ny, nz, d;
            nx = $signed(p[15:0]);
            ny = $signed(p[31:16]);
            nz = $signed(p[47:32]);
            d  = $signed(p[63:48]);
            return nx * x + ny * y + nz * z + d * Q_ONE;
        endfunction

        function void note_item(item_t it);
            verdict_t v;
            longint   lx, ly, lz, hx, hy, hz, r, px, py, pz;
            bit       any_pos;
            lx = $signed(it.lo_x);
            ly = $signed(it.lo_y);
            lz = $signed(it.lo_z);
            hx = $signed(it.hi_x);
            hy = $signed(it.hi_y);
            hz = $signed(it.hi_z);
            v.hit    = 1'b1;
            v.all_in = 1'b0;
            if (it.kind == KIND_SPHERE)
            begin
                n_spheres++;
                r = it.radius;
                for (int i = 0; i < NUM_PLANES; i++)
                    if (plane_dist(plane_reg[i], lx, ly, lz) < -r * Q_ONE)
                        v.hit = 1'b0;
            end
            else
            begin
                n_boxes++;
                v.all_in = 1'b1;
                for (int i = 0; i < NUM_PLANES; i++)
                begin
                    any_pos = 1'b0;
                    for (int c = 0; c < 8; c++)
                    begin
                        px = (c & 1) ? hx : lx;
                        py = (c & 2) ? hy : ly;
                        pz = (c & 4) ? hz : lz;
                        if (plane_dist(plane_reg[i], px, py, pz) > 0)
                            any_pos = 1'b1;
                        else
                            v.all_in = 1'b0;
                    end
                    if (!any_pos)
                        v.hit = 1'b0;
                end
            end
            if (!v.hit)
                n_culled++;
            if (v.all_in)
                n_inside++;
            verdict_q.push_back(v);
        endfunction

        function void check_result(logic t, logic f);
            verdict_t v;
            if (verdict_q.size() == 0)
            begin
                orphans++;
                if (mismatches + orphans <= 10)
                    $display("unexpected result word: touches %b fully_inside %b", t, f);
                return;
            end
            v = verdict_q.pop_front();
            checked++;
            if (t !== v.hit || f !== v.all_in)
            begin
                mismatches++;
                if (mismatches + orphans <= 10)
                    $display("mismatch on result %0d: touches exp %b got %b, fully_inside exp %b got %b",
                             checked, v.hit, t, v.all_in, f);
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function int failures();
            return mismatches + orphans;
        endfunction
    endclass

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      in_valid     = 1'b0;
    logic                      in_ready;
    logic                      kind         = KIND_SPHERE;
    logic signed [COORD_W-1:0] first_x      = '0;
    logic signed [COORD_W-1:0] first_y      = '0;
    logic signed [COORD_W-1:0] first_z      = '0;
    logic signed [COORD_W-1:0] second_x     = '0;
    logic signed [COORD_W-1:0] second_y     = '0;
    logic signed [COORD_W-1:0] second_z     = '0;
    logic        [RAD_W-1:0]   radius       = '0;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index    = '0;
    logic [PLANE_W-1:0]        cfg_data     = '0;
    logic                      out_valid;
    logic                      out_ready    = 1'b0;
    logic                      touches;
    logic                      fully_inside;

    cull_scoreboard board = new();
    logic [63:0]    next_planes [NUM_PLANES];
    bit             calm        = 1'b0;
    int             cycle_count = 0;
    int             n_settings  = 1;

    frustum_cull_sphere_box_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .first_x      (first_x),
        .first_y      (first_y),
        .first_z      (first_z),
        .second_x     (second_x),
        .second_y     (second_y),
        .second_z     (second_z),
        .radius       (radius),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .touches      (touches),
        .fully_inside (fully_inside)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // idle with a chance of 7 percent, never while calm
    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 7);
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !take_break();
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            board.check_result(touches, fully_inside);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] make_plane(logic [15:0] nx, logic [15:0] ny,
                                               logic [15:0] nz, logic [15:0] d);
        return {d, nz, ny, nx};
    endfunction

    function automatic logic [63:0] rand_plane();
        if ($urandom_range(1))
            return {$urandom, $urandom};
        return make_plane(16'($urandom_range(23170) - 11585),
                          16'($urandom_range(23170) - 11585),
                          16'($urandom_range(23170) - 11585),
                          16'($urandom_range(16000) - 8000));
    endfunction

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1, 2:    return 16'($urandom_range(24000) - 12000);
            default:
                case ($urandom_range(3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
        endcase
    endfunction

    // random spheres and boxes, mostly well-formed boxes near the view, some with min above max
    function automatic item_t rand_item();
        item_t it;
        it.kind = $urandom_range(1) ? KIND_BOX : KIND_SPHERE;
        it.lo_x = rand_coord();
        it.lo_y = rand_coord();
        it.lo_z = rand_coord();
        if ($urandom_range(7) == 0)
        begin
            it.hi_x = rand_coord();
            it.hi_y = rand_coord();
            it.hi_z = rand_coord();
        end
        else
        begin
            it.hi_x = it.lo_x + 16'($urandom_range(4000));
            it.hi_y = it.lo_y + 16'($urandom_range(4000));
            it.hi_z = it.lo_z + 16'($urandom_range(4000));
        end
        it.radius = ($urandom_range(2) == 0) ? 15'($urandom) : 15'($urandom_range(3000));
        return it;
    endfunction

    // box fields carry junk on a sphere
    function automatic item_t sphere_at(int x, int y, int z, int r);
        item_t it;
        it.kind   = KIND_SPHERE;
        it.lo_x   = 16'(x);
        it.lo_y   = 16'(y);
        it.lo_z   = 16'(z);
        it.hi_x   = 16'($urandom);
        it.hi_y   = 16'($urandom);
        it.hi_z   = 16'($urandom);
        it.radius = 15'(r);
        return it;
    endfunction

    // radius carries junk on a box
    function automatic item_t box_span(int lx, int ly, int lz, int hx, int hy, int hz);
        item_t it;
        it.kind   = KIND_BOX;
        it.lo_x   = 16'(lx);
        it.lo_y   = 16'(ly);
        it.lo_z   = 16'(lz);
        it.hi_x   = 16'(hx);
        it.hi_y   = 16'(hy);
        it.hi_z   = 16'(hz);
        it.radius = 15'($urandom);
        return it;
    endfunction

    // present one word and hold it until taken
    task automatic send_item(input item_t it);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= it.kind;
        first_x  <= it.lo_x;
        first_y  <= it.lo_y;
        first_z  <= it.lo_z;
        second_x <= it.hi_x;
        second_y <= it.hi_y;
        second_z <= it.hi_z;
        radius   <= it.radius;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        board.note_item(it);
    endtask

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++)
        begin
            send_item(rand_item());
            if ($urandom_range(299) == 0)
                wait_results();
        end
    endtask

    // stop sending and let the pipe empty
    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        board.write_plane(idx, data);
    endtask

    // all six planes plus one write to an unused slot, which must not stick
    task automatic load_planes(input int spare);
        for (int i = REG_LEFT; i <= REG_FAR; i++)
        begin
            if (i == REG_BOTTOM)
                write_reg(spare, {$urandom, $urandom});
            write_reg(i, next_planes[i]);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic load_random_planes(input int spare);
        for (int i = REG_LEFT; i <= REG_FAR; i++)
            next_planes[i] = rand_plane();
        load_planes(spare);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // planes still zero: spheres always kept, boxes always dropped
        send_item(sphere_at(32767, -32768, 0, 0));
        send_item(sphere_at(-32768, 32767, -1, 32767));
        send_item(box_span(-10, -10, -10, 10, 10, 10));
        send_item(box_span(32767, 32767, 32767, -32768, -32768, -32768));
        run_random(100);
        wait_results();

        // axis-aligned view box: |x|,|y| < 8000, 0 < z < 20000
        next_planes[REG_LEFT]   = make_plane(Q_POS, Q_ZERO, Q_ZERO, VIEW_W);
        next_planes[REG_RIGHT]  = make_plane(Q_NEG, Q_ZERO, Q_ZERO, VIEW_W);
        next_planes[REG_TOP]    = make_plane(Q_ZERO, Q_NEG, Q_ZERO, VIEW_W);
        next_planes[REG_BOTTOM] = make_plane(Q_ZERO, Q_POS, Q_ZERO, VIEW_W);
        next_planes[REG_NEAR]   = make_plane(Q_ZERO, Q_ZERO, Q_POS, Q_ZERO);
        next_planes[REG_FAR]    = make_plane(Q_ZERO, Q_ZERO, Q_NEG, VIEW_FAR);
        load_planes(REG_SPARE_LO);

        // sphere edge: distance exactly minus radius is kept, one further is culled
        send_item(sphere_at(0, 0, 10000, 0));
        send_item(sphere_at(-8100, 0, 10000, 100));
        send_item(sphere_at(-8101, 0, 10000, 100));
        send_item(sphere_at(0, 0, -32768, 32767));
        send_item(sphere_at(32767, 32767, 32767, 32767));
        send_item(sphere_at(-32768, -32768, -32768, 0));
        send_item(sphere_at(-32768, 0, 10000, 24768));
        // boxes: inside, straddling, corners on a plane, min above max, outside
        send_item(box_span(-100, -100, 100, 100, 100, 200));
        send_item(box_span(-9000, -100, 100, 100, 100, 200));
        send_item(box_span(-8000, -100, 100, -8000, 100, 200));
        send_item(box_span(-7999, -100, 100, -7999, 100, 200));
        send_item(box_span(100, 100, 200, -100, -100, 100));
        send_item(box_span(-32768, -32768, -32768, 32767, 32767, 32767));
        send_item(box_span(9000, -100, 100, 10000, 100, 200));
        send_item(box_span(-100, -100, 0, 100, 100, 0));
        send_item(box_span(-100, -100, 19999, 100, 100, 20001));
        run_random(250);
        wait_results();
        run_random(250);
        wait_results();

        // every plane bit set
        for (int i = REG_LEFT; i <= REG_FAR; i++)
            next_planes[i] = 64'hFFFF_FFFF_FFFF_FFFF;
        load_planes(REG_SPARE_HI);
        run_random(150);
        wait_results();

        // most positive and most negative plane fields
        next_planes[REG_LEFT]   = make_plane(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        next_planes[REG_RIGHT]  = make_plane(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        next_planes[REG_TOP]    = make_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        next_planes[REG_BOTTOM] = make_plane(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        next_planes[REG_NEAR]   = make_plane(16'h7FFF, Q_ZERO, Q_ZERO, 16'h7FFF);
        next_planes[REG_FAR]    = make_plane(Q_ZERO, Q_ZERO, 16'h8000, Q_ZERO);
        load_planes(REG_SPARE_LO);
        run_random(150);
        wait_results();

        // random plane sets, one of them with no idling on either side
        load_random_planes(REG_SPARE_HI);
        run_random(300);
        wait_results();

        calm = 1'b1;
        load_random_planes(REG_SPARE_LO);
        run_random(300);
        wait_results();
        calm = 1'b0;

        load_random_planes(REG_SPARE_HI);
        run_random(300);
        wait_results();

        repeat (2 * LATENCY) @(posedge clk);
        $display("Covered %0d spheres and %0d boxes over %0d plane settings, from zero planes to extremes.",
                 board.n_spheres, board.n_boxes, n_settings);
        $display("%0d culled, %0d boxes fully inside; %0d results checked, %0d mismatches.",
                 board.n_culled, board.n_inside, board.checked, board.failures());
        if (board.failures() == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
